// ===== sv/skt_pkg.sv =====
package skt_pkg;

  // Table geometry.
  localparam int ENTRIES      = 256;
  localparam int ELEMENT_BITS = 32;
  localparam int SLOT_BITS    = $clog2(ENTRIES);
  localparam int CNT_BITS     = $clog2(ENTRIES + 1);

  // Running hash and the remainder unit, which retires two dividend bits a cycle.
  localparam int HASH_BITS    = 64;
  localparam int DIV_STEPS    = HASH_BITS / 2;
  localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

  // Operation codes carried in the kind field.
  typedef enum logic [1:0] {
    KIND_GET  = 2'd0,
    KIND_SET  = 2'd1,
    KIND_FILL = 2'd2,
    KIND_READ = 2'd3
  } skt_kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic div_step;
    logic rd_issue;
    logic rd_capture;
    logic wr_set;
    logic fill_step;
    logic out_load;
  } skt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic fill_done;
    logic pos_oob;
    logic out_free;
  } skt_stat_t;

endpackage

// ===== sv/skt_ram.sv =====
module skt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/skt_ctrl.sv =====
module skt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tlast,
  input  skt_pkg::skt_kind_t in_kind,
  input  skt_pkg::skt_stat_t stat,
  output logic              in_tready,
  output skt_pkg::skt_cmd_t  cmd
);
  import skt_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DIV  = 7'b0000010,
    S_RD   = 7'b0000100,
    S_RDW  = 7'b0001000,
    S_WR   = 7'b0010000,
    S_FILL = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t    state_r, state_nxt;
  skt_kind_t op_r;

  assign in_tready = (state_r == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.accept = in_tvalid;
        if (in_tvalid && in_tlast) begin
          unique case (in_kind)
            KIND_GET, KIND_SET: state_nxt = S_DIV;
            KIND_FILL:          state_nxt = S_FILL;
            KIND_READ:          state_nxt = stat.pos_oob ? S_OUT : S_RD;
            default:            state_nxt = S_IDLE;
          endcase
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          state_nxt = (op_r == KIND_GET) ? S_RD : S_WR;
        end
      end
      S_RD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_RDW;
      end
      S_RDW: begin
        cmd.rd_capture = 1'b1;
        state_nxt      = S_OUT;
      end
      S_WR: begin
        cmd.wr_set = 1'b1;
        state_nxt  = S_OUT;
      end
      S_FILL: begin
        cmd.fill_step = 1'b1;
        if (stat.fill_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register and the latched operation.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= KIND_GET;
    end else begin
      state_r <= state_nxt;
      if (cmd.accept && in_tlast) begin
        op_r <= in_kind;
      end
    end
  end

endmodule

// ===== sv/skt_dp.sv =====
module skt_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [8:0]                  cfg_wdata,
  input  logic [47:0]                 in_tdata,
  input  logic [2:0]                  in_tuser,
  input  logic                        in_tlast,
  input  skt_pkg::skt_cmd_t           cmd,
  output skt_pkg::skt_stat_t          stat,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [39:0]                 out_tdata,
  output logic [2:0]                  out_tuser
);
  import skt_pkg::*;

  // Input word fields.
  logic [7:0]              in_char;
  logic [ELEMENT_BITS-1:0] in_value;
  logic [7:0]              in_pos;
  skt_kind_t               in_kind;
  logic                    in_char_valid;

  assign in_char       = in_tdata[7:0];
  assign in_value      = in_tdata[39:8];
  assign in_pos        = in_tdata[47:40];
  assign in_kind       = skt_kind_t'(in_tuser[1:0]);
  assign in_char_valid = in_tuser[2];

  logic [CNT_BITS-1:0]     elem_cnt_r;
  logic [CNT_BITS-1:0]     n_slots;
  logic [HASH_BITS-1:0]    hash_r;
  logic [HASH_BITS-1:0]    hash_nxt;
  logic [HASH_BITS-1:0]    quo_r;
  logic [CNT_BITS-1:0]     rem_r;
  logic [CNT_BITS-1:0]     rem_nxt;
  logic [DIV_CNT_BITS-1:0] div_cnt_r;
  logic [CNT_BITS-1:0]     fill_idx_r;
  logic [ELEMENT_BITS-1:0] val_r;
  logic [7:0]              pos_r;
  logic [ENTRIES-1:0]      vld_r;
  logic                    vld_q_r;
  skt_kind_t               res_kind_r;
  logic [7:0]              res_slot_r;
  logic [ELEMENT_BITS-1:0] res_data_r;
  logic                    res_status_r;
  logic                    out_valid_r;
  skt_kind_t               out_kind_r;
  logic [7:0]              out_slot_r;
  logic [ELEMENT_BITS-1:0] out_data_r;
  logic                    out_status_r;
  logic [SLOT_BITS-1:0]    rd_addr;
  logic [SLOT_BITS-1:0]    wr_addr;
  logic [ELEMENT_BITS-1:0] ram_q;
  logic                    last_acc;

  // Slot count in use: zero acts as one, anything above the table size saturates.
  always_comb begin
    n_slots = elem_cnt_r;
    if (elem_cnt_r == '0) begin
      n_slots = CNT_BITS'(1);
    end else if (elem_cnt_r > CNT_BITS'(ENTRIES)) begin
      n_slots = CNT_BITS'(ENTRIES);
    end
  end

  // Hash update: h * 97 + c, with 97 = 64 + 32 + 1.
  always_comb begin
    hash_nxt = hash_r;
    if (in_char_valid) begin
      hash_nxt = (hash_r << 6) + (hash_r << 5) + hash_r + HASH_BITS'(in_char);
    end
  end

  // Two restoring remainder steps per cycle on the top bits of the dividend.
  always_comb begin
    logic [CNT_BITS:0] t1;
    logic [CNT_BITS:0] t2;
    t1 = {rem_r, quo_r[HASH_BITS-1]};
    if (t1 >= {1'b0, n_slots}) begin
      t1 = t1 - {1'b0, n_slots};
    end
    t2 = {t1[CNT_BITS-1:0], quo_r[HASH_BITS-2]};
    if (t2 >= {1'b0, n_slots}) begin
      t2 = t2 - {1'b0, n_slots};
    end
    rem_nxt = t2[CNT_BITS-1:0];
  end

  assign last_acc = cmd.accept && in_tlast;
  assign rd_addr  = (res_kind_r == KIND_READ) ? pos_r[SLOT_BITS-1:0] : rem_r[SLOT_BITS-1:0];
  assign wr_addr  = cmd.fill_step ? fill_idx_r[SLOT_BITS-1:0] : rem_r[SLOT_BITS-1:0];

  // Status back to the controller.
  assign stat.div_done  = (div_cnt_r == DIV_CNT_BITS'(DIV_STEPS - 1));
  assign stat.fill_done = (fill_idx_r == n_slots - CNT_BITS'(1));
  assign stat.pos_oob   = ({1'b0, in_pos} >= n_slots);
  assign stat.out_free  = !out_valid_r || out_tready;

  // Table storage; entries not yet written read as zero through the valid bits.
  skt_ram #(
    .WIDTH (ELEMENT_BITS),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.wr_set || cmd.fill_step),
    .waddr (wr_addr),
    .wdata (val_r),
    .re    (cmd.rd_issue),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // Control state: slot count, hash, valid bits and the output flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elem_cnt_r  <= CNT_BITS'(ENTRIES);
      hash_r      <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        elem_cnt_r <= cfg_wdata;
      end
      if (cmd.accept) begin
        hash_r <= in_tlast ? '0 : hash_nxt;
      end
      if (cmd.wr_set || cmd.fill_step) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Operand capture, remainder unit, fill walk and result registers.
  always_ff @(posedge clk) begin
    if (last_acc) begin
      quo_r        <= hash_nxt;
      rem_r        <= '0;
      div_cnt_r    <= '0;
      fill_idx_r   <= '0;
      val_r        <= in_value;
      pos_r        <= in_pos;
      res_kind_r   <= in_kind;
      res_slot_r   <= (in_kind == KIND_FILL) ? 8'd0 : in_pos;
      res_data_r   <= (in_kind == KIND_FILL) ? in_value : '0;
      res_status_r <= (in_kind == KIND_READ) && stat.pos_oob;
    end
    if (cmd.div_step) begin
      quo_r     <= quo_r << 2;
      rem_r     <= rem_nxt;
      div_cnt_r <= div_cnt_r + DIV_CNT_BITS'(1);
    end
    if (cmd.fill_step) begin
      fill_idx_r <= fill_idx_r + CNT_BITS'(1);
    end
    if (cmd.rd_issue) begin
      vld_q_r    <= vld_r[rd_addr];
      res_slot_r <= 8'(rd_addr);
    end
    if (cmd.rd_capture) begin
      res_data_r <= vld_q_r ? ram_q : '0;
    end
    if (cmd.wr_set) begin
      res_slot_r <= 8'(rem_r[SLOT_BITS-1:0]);
      res_data_r <= val_r;
    end
    if (cmd.out_load) begin
      out_kind_r   <= res_kind_r;
      out_slot_r   <= res_slot_r;
      out_data_r   <= res_data_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_data_r, out_slot_r};
  assign out_tuser  = {out_status_r, out_kind_r};

endmodule

// ===== sv/string_keyed_direct_table.sv =====
// Direct-mapped table of 256 32-bit words addressed by a string name. Each input
// word carries one name character; the word with in_tlast set runs the operation
// named by its kind and yields one output word, other words yield none. At the
// end of a name the 64-bit hash is reduced modulo the slot count by a remainder
// unit retiring two bits a cycle; a get then reads the slot and a set writes it.
// A fill walks the slots in use through the single RAM write port, one slot a
// cycle. A read at position issues and captures a RAM read, or goes straight to
// the result when the position is out of range. The table reads as all zero right
// after reset through per-slot valid flags, with no clearing pass. Character
// words are taken while an earlier result still waits.
module string_keyed_direct_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata,   // element_count
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,    // name_char[7:0], value[39:8], position[47:40]
  input  logic [2:0]  in_tuser,    // kind[1:0], char_valid[2]
  input  logic        in_tlast,    // last_char
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,   // slot[7:0], data[39:8]
  output logic [2:0]  out_tuser    // done_kind[1:0], status[2]
);
  import skt_pkg::*;

  skt_cmd_t  cmd;
  skt_stat_t stat;

  // Sequencer.
  skt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_kind   (skt_kind_t'(in_tuser[1:0])),
    .stat      (stat),
    .in_tready (in_tready),
    .cmd       (cmd)
  );

  // Hash, remainder unit, table and output register.
  skt_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== sv/skt_checker.sv =====
module skt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [2:0]  out_tuser
);
  import skt_pkg::*;

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // The operation started by a name end blocks further input in the cycle after it is accepted.
  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input accepted right after a name end");

  // An out-of-range flag only comes from a positional read, with zero data.
  a_oob_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |->
      (out_tuser[1:0] == KIND_READ) && (out_tdata[39:8] == '0))
    else $error("bad out-of-range result");

  // A fill reports slot zero and no error.
  a_fill_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[1:0] == KIND_FILL) |-> (out_tdata[7:0] == '0) && !out_tuser[2])
    else $error("bad fill result");

endmodule

bind string_keyed_direct_table skt_checker u_skt_checker (.*);
